/* hw/rtl/ptbp_pkg.sv */
// Package for the pulse train builder and player.
// Holds the store geometry, request codes and the structs shared between the modules.
// Depends on nothing.
package ptbp_pkg;

   // Store geometry.
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // Field widths.
   localparam int DUR_W = 30;
   localparam int REP_W = 16;
   localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

   // Request codes.
   typedef enum logic [2:0] {
      REQ_APPEND = 3'd0,
      REQ_CLEAR  = 3'd1,
      REQ_START  = 3'd2,
      REQ_YIELD  = 3'd3,
      REQ_STOP   = 3'd4
   } req_code_type;

   // Input transaction payload.
   typedef struct packed {
      logic [2:0]       req_type;
      logic             seg_level;
      logic [DUR_W-1:0] seg_duration;
   } req_data_type;

   // Result transaction payload.
   typedef struct packed {
      logic             out_level;
      logic [DUR_W-1:0] out_duration;
      logic             end_marker;
      logic [CNT_W-1:0] entry_count;
      logic             dropped;
      logic             running;
   } rsp_data_type;

   // One stored segment.
   typedef struct packed {
      logic             level;
      logic [DUR_W-1:0] duration;
   } entry_type;

   // Store access issued by the controller.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_cmd_type;

   // Result fields known at accept time; the segment may still come from the store.
   typedef struct packed {
      logic             yield_hit;
      logic             use_last;
      entry_type        last_entry;
      logic             end_marker;
      logic [CNT_W-1:0] entry_count;
      logic             dropped;
      logic             running;
   } stage_type;

endpackage

/* hw/rtl/ptbp_store.sv */
// Segment store: one write port and one registered read port.
// Depends on ptbp_pkg for geometry and the access struct.
module ptbp_store (
   input  logic                 clock,
   input  ptbp_pkg::mem_cmd_type mem_cmd,
   output ptbp_pkg::entry_type   rd_data
);

   ptbp_pkg::entry_type mem_array [ptbp_pkg::STORE_DEPTH];
   ptbp_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem_array[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem_array[mem_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ptbp_ctrl.sv */
// Controller: decodes each transaction, updates counters and playback state,
// and issues store accesses. Depends on ptbp_pkg.
module ptbp_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [ptbp_pkg::REP_W-1:0]            csr_wr_data,
   input  logic                                  take,
   input  ptbp_pkg::req_data_type                req_data,
   output ptbp_pkg::mem_cmd_type                 mem_cmd,
   output ptbp_pkg::stage_type                   stage
);

   logic [ptbp_pkg::REP_W-1:0]  repeat_count_ff;
   logic [ptbp_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ptbp_pkg::ADDR_W-1:0] index_ff, index_in;
   logic [ptbp_pkg::REP_W-1:0]  repeats_ff, repeats_in;
   logic                        active_ff, active_in;
   ptbp_pkg::entry_type         last_ff, last_in;

   logic [ptbp_pkg::ADDR_W-1:0] last_addr;
   logic [ptbp_pkg::DUR_W:0]    dur_sum;
   logic [ptbp_pkg::DUR_W-1:0]  dur_sat;
   logic [ptbp_pkg::ADDR_W-1:0] play_addr;
   logic [ptbp_pkg::CNT_W-1:0]  play_next;
   logic                        is_yield;
   logic                        use_last;
   logic                        is_end;
   logic                        is_drop;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_count_ff <= ptbp_pkg::REP_W'(1);
      end else if (csr_wr_en) begin
         repeat_count_ff <= csr_wr_data;
      end
   end

   // Shared terms: last stored entry, merged duration, playback position.
   assign last_addr = ptbp_pkg::ADDR_W'(count_ff - 1'b1);
   assign dur_sum   = {1'b0, last_ff.duration} + {1'b0, req_data.seg_duration};
   assign dur_sat   = dur_sum[ptbp_pkg::DUR_W] ? ptbp_pkg::DUR_MAX
                                               : dur_sum[ptbp_pkg::DUR_W-1:0];
   assign play_addr = ({1'b0, index_ff} >= count_ff) ? '0 : index_ff;
   assign play_next = ptbp_pkg::CNT_W'(play_addr) + 1'b1;

   // Request decode and next state.
   always_comb begin
      count_in   = count_ff;
      index_in   = index_ff;
      repeats_in = repeats_ff;
      active_in  = active_ff;
      last_in    = last_ff;
      mem_cmd    = '0;
      is_yield   = 1'b0;
      use_last   = 1'b0;
      is_end     = 1'b0;
      is_drop    = 1'b0;
      unique case (req_data.req_type)
         ptbp_pkg::REQ_APPEND: begin
            if (count_ff != '0 && last_ff.level == req_data.seg_level) begin
               // Same level as the last segment: extend it.
               last_in.duration = dur_sat;
               mem_cmd.wr_en    = take;
               mem_cmd.wr_addr  = last_addr;
               mem_cmd.wr_data  = last_in;
            end else if (count_ff < ptbp_pkg::CNT_W'(ptbp_pkg::STORE_DEPTH)) begin
               last_in.level    = req_data.seg_level;
               last_in.duration = req_data.seg_duration;
               mem_cmd.wr_en    = take;
               mem_cmd.wr_addr  = count_ff[ptbp_pkg::ADDR_W-1:0];
               mem_cmd.wr_data  = last_in;
               count_in         = count_ff + 1'b1;
            end else begin
               is_drop = 1'b1;
            end
         end
         ptbp_pkg::REQ_CLEAR: begin
            count_in = '0;
            index_in = '0;
         end
         ptbp_pkg::REQ_START: begin
            repeats_in = repeat_count_ff;
            index_in   = '0;
            active_in  = 1'b1;
         end
         ptbp_pkg::REQ_YIELD: begin
            if (repeats_ff == '0 || !active_ff || count_ff == '0) begin
               active_in = 1'b0;
               is_end    = 1'b1;
            end else begin
               is_yield        = 1'b1;
               // The last entry may have been merged just now; take it from the register.
               use_last        = (play_addr == last_addr);
               mem_cmd.rd_en   = take;
               mem_cmd.rd_addr = play_addr;
               if (play_next == count_ff) begin
                  repeats_in = repeats_ff - 1'b1;
                  index_in   = '0;
               end else begin
                  index_in = play_next[ptbp_pkg::ADDR_W-1:0];
               end
            end
         end
         ptbp_pkg::REQ_STOP: begin
            active_in = 1'b0;
            index_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // Playback and count state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         index_ff   <= '0;
         repeats_ff <= '0;
         active_ff  <= 1'b0;
      end else if (take) begin
         count_ff   <= count_in;
         index_ff   <= index_in;
         repeats_ff <= repeats_in;
         active_ff  <= active_in;
      end
   end

   // Copy of the last stored segment.
   always_ff @(posedge clock) begin
      if (take) begin
         last_ff <= last_in;
      end
   end

   // Fields handed to the result register.
   always_comb begin
      stage.yield_hit   = is_yield;
      stage.use_last    = use_last;
      stage.last_entry  = last_ff;
      stage.end_marker  = is_end;
      stage.entry_count = count_in;
      stage.dropped     = is_drop;
      stage.running     = active_in;
   end

endmodule

/* hw/rtl/pulse_train_builder_player.sv */
// Top level of the pulse train builder and player.
// Depends on ptbp_pkg, ptbp_ctrl and ptbp_store.
//
// Usage:
// - Request channel (req_valid, req_ready, req_data) carries one command per
//   transaction: append a segment, clear, start, yield the next segment, stop.
// - Response channel (rsp_valid, rsp_ready, rsp_data) returns exactly one
//   result per request, in order.
// - csr_wr_en / csr_wr_data write the repeat count; write it only while idle.
// - Latency: a result is valid in the cycle after its request is accepted.
// - Throughput: one transaction per cycle unless the receiver stalls. The state
//   update and the store access of a request finish at its accept edge; the
//   store read data and the result register are ready in the cycle after.
// - A yield of the last stored entry uses a register copy of that entry.
// - Reset clears the counters, stops playback, sets the repeat count to one
//   and empties the result register. The store itself is not cleared.
// - While the receiver stalls, the held result stays stable and one more
//   request is taken only as the held result is taken.
module pulse_train_builder_player (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ptbp_pkg::req_data_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ptbp_pkg::rsp_data_type      rsp_data,
   input  logic                        csr_wr_en,
   input  logic [ptbp_pkg::REP_W-1:0]  csr_wr_data
);

   logic                  take;
   logic                  rsp_valid_ff;
   ptbp_pkg::stage_type   stage;
   ptbp_pkg::stage_type   stage_ff;
   ptbp_pkg::mem_cmd_type mem_cmd;
   ptbp_pkg::entry_type   rd_data;
   ptbp_pkg::entry_type   seg;

   // Accept when the result register is empty or being emptied.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   ptbp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .req_data    (req_data),
      .mem_cmd     (mem_cmd),
      .stage       (stage)
   );

   ptbp_store u_store (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= stage;
      end
   end

   // Yielded segment comes from the store or from the last-entry copy.
   always_comb begin
      if (!stage_ff.yield_hit) begin
         seg = '0;
      end else if (stage_ff.use_last) begin
         seg = stage_ff.last_entry;
      end else begin
         seg = rd_data;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.out_level    = seg.level;
   assign rsp_data.out_duration = seg.duration;
   assign rsp_data.end_marker   = stage_ff.end_marker;
   assign rsp_data.entry_count  = stage_ff.entry_count;
   assign rsp_data.dropped      = stage_ff.dropped;
   assign rsp_data.running      = stage_ff.running;

endmodule

/* hw/rtl/ptbp_checker.sv */
// Port-level checks for the pulse train builder and player, with its bind.
// Depends on ptbp_pkg and pulse_train_builder_player.
module ptbp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input ptbp_pkg::rsp_data_type rsp_data
);

   // Every accepted transaction shows a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no result");

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // An end marker carries no segment and leaves playback stopped.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_marker |->
         !rsp_data.running && !rsp_data.out_level && rsp_data.out_duration == '0)
      else $error("end marker with segment data or running");

   // A dropped append only happens with a full store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |->
         rsp_data.entry_count == ptbp_pkg::CNT_W'(ptbp_pkg::STORE_DEPTH))
      else $error("drop reported with room in the store");

   // No result is shown in the first cycle after reset is released.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pulse_train_builder_player ptbp_checker u_ptbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
